// ----- src/tangent_frame_local_to_world_assert.svh -----
// assertion macros for the tangent frame block
// no dependencies; included by modules that check their own pipelines
`ifndef TANGENT_FRAME_LOCAL_TO_WORLD_ASSERT_SVH
`define TANGENT_FRAME_LOCAL_TO_WORLD_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define TFLW_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is low
`define TFLW_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/tflw_pkg.sv -----
// shared types and constants of the tangent frame local-to-world block
// no dependencies; imported by tflw_div and the top level
`timescale 1ns / 1ps

package tflw_pkg;

  // fixed point
  localparam int unsigned Q14_SHIFT = 14;
  localparam int unsigned Q14_ONE   = 1 << Q14_SHIFT;

  // rounding divider: quotient bits, numerator and divisor widths
  localparam int unsigned DIV_NW   = 32;
  localparam int unsigned DIV_DW   = 17;
  localparam int unsigned DIV_QW   = 18;
  localparam int unsigned DIV_STEP = 3;
  localparam int unsigned DIV_NST  = DIV_QW / DIV_STEP;

  // datapath widths
  localparam int unsigned TW = 18;  // basis component
  localparam int unsigned PW = 50;  // offset times basis component
  localparam int unsigned AW = 52;  // sum of three products, Q22.30
  localparam int unsigned RW = AW - Q14_SHIFT;  // rounded sum, Q22.16

  // configuration port
  localparam int unsigned PADDR_W = 3;

  typedef enum logic {
    REG_TANGENT_MODE = 1'b0
  } reg_idx_e;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] offset_z;
  } req_t;

  typedef struct packed {
    logic signed [31:0] world_x;
    logic signed [31:0] world_y;
    logic signed [31:0] world_z;
  } res_t;

endpackage

// ----- src/tflw_div.sv -----
// pipelined restoring divider, DIV_STEP quotient bits per stage
// depends on tflw_pkg for widths; quotient must fit in DIV_QW bits
`timescale 1ns / 1ps

module tflw_div
  import tflw_pkg::*;
(
  input  logic              clk_i,
  input  logic [DIV_NW-1:0] num_i,
  input  logic [DIV_DW-1:0] den_i,
  output logic [DIV_QW-1:0] quo_o
);

  logic [DIV_NW-1:0] num_q [DIV_NST];
  logic [DIV_DW-1:0] den_q [DIV_NST];
  logic [DIV_DW-1:0] rem_q [DIV_NST];
  logic [DIV_QW-1:0] quo_q [DIV_NST];

  for (genvar k = 0; k < DIV_NST; k++) begin : g_stage
    logic [DIV_NW-1:0] num_in;
    logic [DIV_DW-1:0] den_in;
    logic [DIV_DW-1:0] rem_in;
    logic [DIV_QW-1:0] quo_in;
    logic [DIV_DW-1:0] rem_d;
    logic [DIV_QW-1:0] quo_d;
    logic [DIV_DW:0]   trial;

    if (k == 0) begin : g_first
      // upper numerator bits are already below the divisor
      assign num_in = num_i;
      assign den_in = den_i;
      assign rem_in = DIV_DW'(num_i[DIV_NW-1:DIV_QW]);
      assign quo_in = '0;
    end else begin : g_rest
      assign num_in = num_q[k-1];
      assign den_in = den_q[k-1];
      assign rem_in = rem_q[k-1];
      assign quo_in = quo_q[k-1];
    end

    always_comb begin
      rem_d = rem_in;
      quo_d = quo_in;
      trial = '0;
      for (int j = 0; j < DIV_STEP; j++) begin
        trial = {rem_d, num_in[DIV_QW-1-k*DIV_STEP-j]};
        if (trial >= {1'b0, den_in}) begin
          rem_d = DIV_DW'(trial - {1'b0, den_in});
          quo_d[DIV_QW-1-k*DIV_STEP-j] = 1'b1;
        end else begin
          rem_d = trial[DIV_DW-1:0];
        end
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k] <= num_in;
      den_q[k] <= den_in;
      rem_q[k] <= rem_d;
      quo_q[k] <= quo_d;
    end
  end

  assign quo_o = quo_q[DIV_NST-1];

endmodule

// ----- src/tangent_frame_local_to_world.sv -----
// tangent frame local-to-world transform, top level; uses tflw_pkg and tflw_div
// a result strobes res_valid_o when its input transfer reaches the end of the valid chain
// throughput: one transfer per cycle, busy never rises; the divider and the
// multiply/add stages are fully pipelined, the three rounding divisions set the depth
// reset: pipeline valid bits clear, tangent_mode resets to 1; no receiver stall
`timescale 1ns / 1ps
`include "tangent_frame_local_to_world_assert.svh"

module tangent_frame_local_to_world
  import tflw_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  req_t               req_i,
  output logic               res_valid_o,
  output res_t               res_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int unsigned ST_BAS  = 3 + DIV_NST;  // basis register stage
  localparam int unsigned NSTG    = ST_BAS + 5;   // total register stages
  localparam int unsigned NPOS    = NSTG - ST_BAS - 1;
  localparam int unsigned ST_ACC  = NSTG - 3;
  localparam int unsigned QUO_MAX = 4 * Q14_ONE;
  localparam int unsigned HALF    = Q14_ONE / 2;

  // configuration
  logic mode_q;
  logic reg_sel;

  assign reg_sel = (paddr[PADDR_W-1] == REG_TANGENT_MODE);
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? {31'b0, mode_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b1;
    end else if (psel && penable && pwrite && reg_sel) begin
      mode_q <= pwdata[0];
    end
  end

  // handshake and valid chain
  logic            accept;
  logic [NSTG-1:0] vld_q;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[NSTG-2:0], accept};
    end
  end

  // item line through the divider stages
  req_t req_q [ST_BAS];

  always_ff @(posedge clk_i) begin
    req_q[0] <= req_i;
    for (int i = 1; i < ST_BAS; i++) begin
      req_q[i] <= req_q[i-1];
    end
  end

  // stage 1: normal magnitudes, squares and cross product, |d| = 1 + |nz|
  logic [15:0] ax, ay, az;
  logic [31:0] sqx_q, sqy_q, sxy_q;
  logic [15:0] ad_q;

  assign ax = req_i.normal_x[15] ? 16'(-req_i.normal_x) : 16'(req_i.normal_x);
  assign ay = req_i.normal_y[15] ? 16'(-req_i.normal_y) : 16'(req_i.normal_y);
  assign az = req_i.normal_z[15] ? 16'(-req_i.normal_z) : 16'(req_i.normal_z);

  always_ff @(posedge clk_i) begin
    sqx_q <= 32'(ax) * 32'(ax);
    sqy_q <= 32'(ay) * 32'(ay);
    sxy_q <= 32'(ax) * 32'(ay);
    ad_q  <= 16'(Q14_ONE) + az;
  end

  // stage 2: round-to-nearest as floor((2m + d) / 2d)
  logic [DIV_NW-1:0] num_u_q, num_v_q, num_p_q;
  logic [DIV_DW-1:0] den_q;

  always_ff @(posedge clk_i) begin
    num_u_q <= {sqx_q[DIV_NW-2:0], 1'b0} + DIV_NW'(ad_q);
    num_v_q <= {sqy_q[DIV_NW-2:0], 1'b0} + DIV_NW'(ad_q);
    num_p_q <= {sxy_q[DIV_NW-2:0], 1'b0} + DIV_NW'(ad_q);
    den_q   <= {ad_q, 1'b0};
  end

  logic [DIV_QW-1:0] quo_u, quo_v, quo_p;

  tflw_div u_div_u (.clk_i(clk_i), .num_i(num_u_q), .den_i(den_q), .quo_o(quo_u));
  tflw_div u_div_v (.clk_i(clk_i), .num_i(num_v_q), .den_i(den_q), .quo_o(quo_v));
  tflw_div u_div_p (.clk_i(clk_i), .num_i(num_p_q), .den_i(den_q), .quo_o(quo_p));

  // basis stage: columns t1, t2, n (identity when tangent mode is off)
  req_t                 rb;
  logic                 neg;
  logic signed [TW-1:0] one, u_s, v_s, p_s, nx_e, ny_e, nz_e;
  logic signed [TW-1:0] bas_d [3][3];
  logic signed [TW-1:0] bas_q [3][3];

  assign rb   = req_q[ST_BAS-2];
  assign neg  = rb.normal_z[15];
  assign one  = TW'(Q14_ONE);
  assign u_s  = signed'(TW'(quo_u));
  assign v_s  = signed'(TW'(quo_v));
  assign p_s  = (rb.normal_x[15] ^ rb.normal_y[15]) ? -signed'(TW'(quo_p))
                                                     : signed'(TW'(quo_p));
  assign nx_e = TW'(rb.normal_x);
  assign ny_e = TW'(rb.normal_y);
  assign nz_e = TW'(rb.normal_z);

  always_comb begin
    if (mode_q) begin
      bas_d[0][0] = one - u_s;
      bas_d[0][1] = -p_s;
      bas_d[0][2] = neg ? nx_e : -nx_e;
      bas_d[1][0] = neg ? p_s : -p_s;
      bas_d[1][1] = neg ? (v_s - one) : (one - v_s);
      bas_d[1][2] = -ny_e;
      bas_d[2][0] = nx_e;
      bas_d[2][1] = ny_e;
      bas_d[2][2] = nz_e;
    end else begin
      for (int c = 0; c < 3; c++) begin
        for (int a = 0; a < 3; a++) begin
          bas_d[c][a] = (c == a) ? one : '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    bas_q <= bas_d;
  end

  // products, two-step sum, rounding, point add
  req_t                 rp;
  logic signed [31:0]   off_s [3];
  logic signed [31:0]   pos_s [3];
  logic signed [PW-1:0] prod_q  [3][3];
  logic signed [AW-1:0] part_q  [3];
  logic signed [PW-1:0] third_q [3];
  logic signed [AW-1:0] acc_q   [3];
  logic signed [RW-1:0] rnd_q   [3];
  logic signed [31:0]   pos_q   [NPOS][3];
  logic signed [RW:0]   sum     [3];
  logic signed [31:0]   wld     [3];
  res_t                 res_q;

  assign rp       = req_q[ST_BAS-1];
  assign off_s[0] = rp.offset_x;
  assign off_s[1] = rp.offset_y;
  assign off_s[2] = rp.offset_z;
  assign pos_s[0] = rp.pos_x;
  assign pos_s[1] = rp.pos_y;
  assign pos_s[2] = rp.pos_z;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      sum[a] = (RW+1)'(rnd_q[a]) + (RW+1)'(pos_q[NPOS-1][a]);
      if (&sum[a][RW:31] || ~|sum[a][RW:31]) begin
        wld[a] = sum[a][31:0];
      end else if (sum[a][RW]) begin
        wld[a] = 32'sh8000_0000;
      end else begin
        wld[a] = 32'sh7fff_ffff;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q[0] <= pos_s;
    for (int i = 1; i < NPOS; i++) begin
      pos_q[i] <= pos_q[i-1];
    end
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        prod_q[a][c] <= PW'(off_s[c]) * PW'(bas_q[c][a]);
      end
      part_q[a]  <= AW'(prod_q[a][0]) + AW'(prod_q[a][1]);
      third_q[a] <= prod_q[a][2];
      acc_q[a]   <= part_q[a] + AW'(third_q[a]);
      // half away from zero: bias by half, one less when negative
      rnd_q[a]   <= RW'((acc_q[a] + (acc_q[a][AW-1] ? AW'(HALF - 1) : AW'(HALF)))
                        >>> Q14_SHIFT);
    end
    res_q.world_x <= wld[0];
    res_q.world_y <= wld[1];
    res_q.world_z <= wld[2];
  end

  assign res_valid_o = vld_q[NSTG-1];
  assign res_o       = res_q;

  // checks
  `TFLW_ASSERT_IMP(a_res_has_src, clk_i, rst_ni, res_valid_o, $past(accept, NSTG), "result strobe without a matching input transfer")
  `TFLW_ASSERT_IMP(a_quo_bound, clk_i, rst_ni, vld_q[ST_BAS-2], (quo_u <= DIV_QW'(QUO_MAX)) && (quo_v <= DIV_QW'(QUO_MAX)) && (quo_p <= DIV_QW'(QUO_MAX)), "divider quotient out of range")

  for (genvar a = 0; a < 3; a++) begin : g_chk
    `TFLW_ASSERT_NXT(a_rnd_sign, clk_i, rst_ni, vld_q[ST_ACC] && !acc_q[a][AW-1], !rnd_q[a][RW-1], "rounding flipped the sign of a non-negative sum")
  end

endmodule
